### hdl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply core: command codes,
// fixed field widths and the control and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 3;
  localparam int ELEM_W = 16;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 40;

  localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_left;
    logic             wr_right;
    logic             rd_en;
    logic             rd_first;
    logic             load_out;
    logic             out_last;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
  } mm_ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mm_stat_t;

endpackage

### hdl/mm_cmd_if.sv
// ----------------------------------------------------------------------------
// mm_cmd_if
// Command channel: load and compute beats into the matrix multiply core.
// ----------------------------------------------------------------------------
interface mm_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [mm_pkg::CMD_W-1:0]     command;
  logic        [mm_pkg::IDX_W-1:0]     row_index;
  logic        [mm_pkg::IDX_W-1:0]     col_index;
  logic signed [mm_pkg::ELEM_W-1:0]    element;

  modport source (output valid, command, row_index, col_index, element, input ready);
  modport sink (input valid, command, row_index, col_index, element, output ready);
endinterface

### hdl/mm_res_if.sv
// ----------------------------------------------------------------------------
// mm_res_if
// Result channel: product element beats out of the matrix multiply core.
// ----------------------------------------------------------------------------
interface mm_res_if;
  logic                                valid;
  logic                                ready;
  logic        [mm_pkg::IDX_W-1:0]     out_row;
  logic        [mm_pkg::IDX_W-1:0]     out_col;
  logic signed [mm_pkg::PROD_W-1:0]    product;
  logic                                last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink (input valid, out_row, out_col, product, last, output ready);
endinterface

### hdl/mm_datapath.sv
// ----------------------------------------------------------------------------
// mm_datapath
// Operand memories with per-entry valid bits, a pipelined 16x16 multiplier,
// a 40-bit accumulator and the result output register.
// ----------------------------------------------------------------------------
module mm_datapath #(
  parameter int LDEPTH = 16,
  parameter int RDEPTH = 16,
  parameter int LAW    = 4,
  parameter int RAW    = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mm_pkg::mm_ctrl_t                 ctrl,
  output mm_pkg::mm_stat_t                 stat,
  input  logic [LAW-1:0]                   left_addr,
  input  logic [RAW-1:0]                   right_addr,
  input  logic signed [mm_pkg::ELEM_W-1:0] element,
  mm_res_if.source                         res
);

  logic signed [mm_pkg::ELEM_W-1:0] lmem [0:LDEPTH-1];
  logic signed [mm_pkg::ELEM_W-1:0] rmem [0:RDEPTH-1];
  logic        [LDEPTH-1:0]         lvld;
  logic        [RDEPTH-1:0]         rvld;

  logic signed [mm_pkg::ELEM_W-1:0] a_data;
  logic signed [mm_pkg::ELEM_W-1:0] b_data;
  logic                             a_ok;
  logic                             b_ok;
  logic                             s1_vld;
  logic                             s1_first;
  logic signed [mm_pkg::MUL_W-1:0]  mul;
  logic                             s2_vld;
  logic                             s2_first;
  logic signed [mm_pkg::PROD_W-1:0] acc;
  logic signed [mm_pkg::PROD_W-1:0] mul_ext;
  logic signed [mm_pkg::ELEM_W-1:0] a_op;
  logic signed [mm_pkg::ELEM_W-1:0] b_op;
  logic                             out_valid;

  // Memory writes and registered reads. Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (ctrl.wr_left) begin
      lmem[left_addr] <= element;
    end
    if (ctrl.wr_right) begin
      rmem[right_addr] <= element;
    end
    if (ctrl.rd_en) begin
      a_data <= lmem[left_addr];
      b_data <= rmem[right_addr];
      a_ok   <= lvld[left_addr];
      b_ok   <= rvld[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvld <= '0;
      rvld <= '0;
    end else begin
      if (ctrl.wr_left) begin
        lvld[left_addr] <= 1'b1;
      end
      if (ctrl.wr_right) begin
        rvld[right_addr] <= 1'b1;
      end
    end
  end

  assign a_op    = a_ok ? a_data : '0;
  assign b_op    = b_ok ? b_data : '0;
  assign mul_ext = mm_pkg::PROD_W'(mul);

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= ctrl.rd_en;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      s1_first <= ctrl.rd_first;
    end
    if (s1_vld) begin
      mul      <= a_op * b_op;
      s2_first <= s1_first;
    end
    if (s2_vld) begin
      acc <= s2_first ? mul_ext : acc + mul_ext;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      res.out_row <= ctrl.out_row;
      res.out_col <= ctrl.out_col;
      res.product <= acc;
      res.last    <= ctrl.out_last;
    end
  end

  assign res.valid      = out_valid;
  assign stat.pipe_busy = s1_vld | s2_vld;
  assign stat.out_free  = ~out_valid | res.ready;

endmodule

### hdl/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Controller: decodes command beats, checks load indexes and steps the row,
// column and inner counters of a compute pass.
// ----------------------------------------------------------------------------
module mm_ctrl #(
  parameter int ROWS  = 4,
  parameter int INNER = 4,
  parameter int COLS  = 4,
  parameter int LAW   = 4,
  parameter int RAW   = 4
) (
  input  logic             clk,
  input  logic             rst,
  mm_cmd_if.sink           cmd,
  output mm_pkg::mm_ctrl_t ctrl,
  input  mm_pkg::mm_stat_t stat,
  output logic [LAW-1:0]   left_addr,
  output logic [RAW-1:0]   right_addr
);

  localparam int RW = (ROWS  > 1) ? $clog2(ROWS)  : 1;
  localparam int KW = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int CW = (COLS  > 1) ? $clog2(COLS)  : 1;
  localparam int XW = mm_pkg::IDX_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [RW-1:0] i_cnt;
  logic [RW-1:0] i_cnt_next;
  logic [CW-1:0] j_cnt;
  logic [CW-1:0] j_cnt_next;
  logic [KW-1:0] k_cnt;
  logic [KW-1:0] k_cnt_next;
  logic          accept;
  logic          left_ok;
  logic          right_ok;
  logic          i_last;
  logic          j_last;
  logic          k_last;

  assign accept = cmd.valid & cmd.ready;
  assign left_ok  = (XW'(cmd.row_index) < XW'(ROWS))  && (XW'(cmd.col_index) < XW'(INNER));
  assign right_ok = (XW'(cmd.row_index) < XW'(INNER)) && (XW'(cmd.col_index) < XW'(COLS));
  assign i_last = (i_cnt == RW'(ROWS - 1));
  assign j_last = (j_cnt == CW'(COLS - 1));
  assign k_last = (k_cnt == KW'(INNER - 1));
  assign cmd.ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    k_cnt_next = k_cnt;
    ctrl       = '0;
    ctrl.out_row  = mm_pkg::IDX_W'(i_cnt);
    ctrl.out_col  = mm_pkg::IDX_W'(j_cnt);
    ctrl.out_last = i_last & j_last;
    left_addr  = LAW'(i_cnt * INNER + k_cnt);
    right_addr = RAW'(k_cnt * COLS + j_cnt);
    unique case (state)
      ST_IDLE: begin
        left_addr  = LAW'(cmd.row_index * INNER + cmd.col_index);
        right_addr = RAW'(cmd.row_index * COLS + cmd.col_index);
        if (accept) begin
          ctrl.wr_left  = (cmd.command == mm_pkg::CMD_LOAD_LEFT) && left_ok;
          ctrl.wr_right = (cmd.command == mm_pkg::CMD_LOAD_RIGHT) && right_ok;
          if (cmd.command == mm_pkg::CMD_COMPUTE) begin
            i_cnt_next = '0;
            j_cnt_next = '0;
            k_cnt_next = '0;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        ctrl.rd_en    = 1'b1;
        ctrl.rd_first = (k_cnt == '0);
        if (k_last) begin
          k_cnt_next = '0;
          state_next = ST_DRAIN;
        end else begin
          k_cnt_next = k_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The accumulator is final once the multiply pipeline is empty.
        if (!stat.pipe_busy && stat.out_free) begin
          ctrl.load_out = 1'b1;
          if (i_last && j_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
            if (j_last) begin
              j_cnt_next = '0;
              i_cnt_next = i_cnt + 1'b1;
            end else begin
              j_cnt_next = j_cnt + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      k_cnt <= k_cnt_next;
    end
  end

  a_load_out_safe: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (stat.out_free && !stat.pipe_busy))
    else $error("result loaded while pipeline busy or output full");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |-> !(ctrl.wr_left || ctrl.wr_right))
    else $error("memory write during a compute read");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (ctrl.load_out && ctrl.out_last) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after last element");

endmodule

### hdl/matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_core
// Signed ROWS x INNER by INNER x COLS integer matrix multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel takes one beat per command. A load left or load right
//   beat writes one 16-bit element at (row_index, col_index); an index
//   outside the operand is dropped. Loads are taken one per cycle while idle
//   and give no result. A compute beat emits ROWS*COLS beats on the res
//   channel in row-major order, each the exact 40-bit sum of products, with
//   last set on the final one.
//   Each product element takes INNER memory reads of the one-port operand
//   stores, then passes the multiplier and accumulator pipeline registers
//   before the output register loads. cmd.ready is low while a compute
//   pass runs and returns the cycle after the last element loads into the
//   output register.
//   When the receiver stalls, the output register holds its beat and the
//   pass waits in front of it. Reset clears every operand element to zero
//   (per-entry valid bits) and empties the output register; operands keep
//   their contents across computes.
// ----------------------------------------------------------------------------
module matrix_multiply_core #(
  parameter int ROWS  = 4,
  parameter int INNER = 4,
  parameter int COLS  = 4
) (
  input logic    clk,
  input logic    rst,
  mm_cmd_if.sink cmd,
  mm_res_if.source res
);

  localparam int LDEPTH = ROWS * INNER;
  localparam int RDEPTH = INNER * COLS;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  mm_pkg::mm_ctrl_t ctrl;
  mm_pkg::mm_stat_t stat;
  logic [LAW-1:0]   left_addr;
  logic [RAW-1:0]   right_addr;

  mm_ctrl #(
    .ROWS  (ROWS),
    .INNER (INNER),
    .COLS  (COLS),
    .LAW   (LAW),
    .RAW   (RAW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .ctrl       (ctrl),
    .stat       (stat),
    .left_addr  (left_addr),
    .right_addr (right_addr)
  );

  mm_datapath #(
    .LDEPTH (LDEPTH),
    .RDEPTH (RDEPTH),
    .LAW    (LAW),
    .RAW    (RAW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .left_addr  (left_addr),
    .right_addr (right_addr),
    .element    (cmd.element),
    .res        (res)
  );

endmodule
